// ===== rtl/core/mvm_pkg.sv =====
package mvm_pkg;

	// Default sizes of the vector store and of one element
	localparam int DEF_MAX_COLS   = 1024;
	localparam int DEF_VALUE_BITS = 16;

	// Configuration registers
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;
	localparam int NUM_COLS_W  = 11;
	localparam int NUM_ROWS_W  = 16;
	localparam int FIRST_ROW_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ROW = 2'd2;

	localparam logic [NUM_COLS_W-1:0]  NUM_COLS_RESET  = 11'd1024;
	localparam logic [NUM_ROWS_W-1:0]  NUM_ROWS_RESET  = 16'd1024;
	localparam logic [FIRST_ROW_W-1:0] FIRST_ROW_RESET = 16'd0;

	// Item kinds carried on tuser
	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_MATRIX = 1'b1;

	// Result fields
	localparam int ROW_IDX_W  = 17;
	localparam int ACC_W      = 42;
	localparam int OUT_DATA_W = 64;
	localparam int OUT_PAD_W  = OUT_DATA_W - ROW_IDX_W - ACC_W;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Per-element control passed from front to back
	typedef struct packed {
		logic                 first;
		logic                 last;
		logic [ROW_IDX_W-1:0] row_index;
	} mvm_ctl_t;

endpackage

// ===== rtl/core/mvm_front.sv =====
module mvm_front import mvm_pkg::*; #(
	parameter int MAX_COLS   = DEF_MAX_COLS,
	parameter int VALUE_BITS = DEF_VALUE_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         in_command,
	input  logic signed [VALUE_BITS-1:0] in_value,
	input  logic [QCNT_W-1:0]            queue_count,
	output logic                         push,
	output mvm_ctl_t                     push_ctl,
	output logic signed [VALUE_BITS-1:0] push_value,
	output logic signed [VALUE_BITS-1:0] push_vec
);

	localparam int COL_W = $clog2(MAX_COLS);
	localparam int CMP_W = (COL_W + 1 > NUM_COLS_W) ? COL_W + 1 : NUM_COLS_W;

	logic [NUM_COLS_W-1:0]  num_cols_q;
	logic [NUM_ROWS_W-1:0]  num_rows_q;
	logic [FIRST_ROW_W-1:0] first_row_q;

	logic [COL_W-1:0]      load_q;
	logic [COL_W-1:0]      col_q;
	logic [NUM_ROWS_W-1:0] row_q;

	logic [VALUE_BITS-1:0] vec_mem [MAX_COLS];

	logic                         valid_s1;
	mvm_ctl_t                     ctl_s1;
	logic signed [VALUE_BITS-1:0] value_s1;
	logic signed [VALUE_BITS-1:0] vec_s1;

	logic                  accept, load_beat, matrix_beat;
	logic [CMP_W-1:0]      num_cols_x, eff_cols, load_next, col_next;
	logic                  load_wrap, row_end;
	logic [NUM_ROWS_W:0]   row_next;
	logic                  row_wrap;
	logic [ROW_IDX_W-1:0]  row_index;

	// Keep room in the queue for every element in flight
	assign in_ready = ({1'b0, queue_count} + {{QCNT_W{1'b0}}, valid_s1})
		< (QCNT_W + 1)'(QUEUE_DEPTH);

	assign accept      = in_valid & in_ready;
	assign load_beat   = accept & (in_command == CMD_LOAD);
	assign matrix_beat = accept & (in_command == CMD_MATRIX);

	// Clamp the column count to 1..MAX_COLS
	always_comb begin
		num_cols_x = CMP_W'(num_cols_q);
		if (num_cols_q == '0) begin
			eff_cols = CMP_W'(1);
		end else if (num_cols_x > CMP_W'(MAX_COLS)) begin
			eff_cols = CMP_W'(MAX_COLS);
		end else begin
			eff_cols = num_cols_x;
		end
	end

	assign load_next = CMP_W'(load_q) + CMP_W'(1);
	assign load_wrap = load_next >= eff_cols;
	assign col_next  = CMP_W'(col_q) + CMP_W'(1);
	assign row_end   = col_next >= eff_cols;
	assign row_next  = {1'b0, row_q} + (NUM_ROWS_W + 1)'(1);
	assign row_wrap  = row_next >= {1'b0, num_rows_q};
	assign row_index = ROW_IDX_W'(first_row_q) + ROW_IDX_W'(row_q);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_cols_q  <= NUM_COLS_RESET;
			num_rows_q  <= NUM_ROWS_RESET;
			first_row_q <= FIRST_ROW_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_NUM_COLS:  num_cols_q  <= cfg_wdata[NUM_COLS_W-1:0];
				CFG_NUM_ROWS:  num_rows_q  <= cfg_wdata[NUM_ROWS_W-1:0];
				CFG_FIRST_ROW: first_row_q <= cfg_wdata[FIRST_ROW_W-1:0];
				default: ;
			endcase
		end
	end

	// Load, column and row positions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_q   <= '0;
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= matrix_beat;
			if (load_beat) begin
				load_q <= load_wrap ? '0 : load_next[COL_W-1:0];
				// Element zero starts a new vector and a new pass over the rows
				if (load_q == '0) begin
					col_q <= '0;
					row_q <= '0;
				end
			end else if (matrix_beat) begin
				if (row_end) begin
					col_q <= '0;
					row_q <= row_wrap ? '0 : row_next[NUM_ROWS_W-1:0];
				end else begin
					col_q <= col_next[COL_W-1:0];
				end
			end
		end
	end

	// Vector store: write on a load beat, registered read on a matrix beat
	always_ff @(posedge clk) begin
		if (load_beat) begin
			vec_mem[load_q] <= in_value;
		end
		if (matrix_beat) begin
			vec_s1           <= vec_mem[col_q];
			value_s1         <= in_value;
			ctl_s1.first     <= (col_q == '0);
			ctl_s1.last      <= row_end;
			ctl_s1.row_index <= row_index;
		end
	end

	assign push       = valid_s1;
	assign push_ctl   = ctl_s1;
	assign push_value = value_s1;
	assign push_vec   = vec_s1;

endmodule

// ===== rtl/core/mvm_queue.sv =====
module mvm_queue import mvm_pkg::*; #(
	parameter int WIDTH = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [WIDTH-1:0]  push_data,
	input  logic              pop,
	output logic [WIDTH-1:0]  pop_data,
	output logic              nonempty,
	output logic [QCNT_W-1:0] count
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	logic [WIDTH-1:0] slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		r = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
		return r;
	endfunction

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= ptr_inc(wr_q);
			end
			if (pop) begin
				rd_q <= ptr_inc(rd_q);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	// Store the pushed beat
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	assign pop_data = slot_q[rd_q];
	assign nonempty = (count_q != '0);
	assign count    = count_q;

endmodule

// ===== rtl/core/mvm_back.sv =====
module mvm_back import mvm_pkg::*; #(
	parameter int VALUE_BITS = DEF_VALUE_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         pop_valid,
	output logic                         pop,
	input  mvm_ctl_t                     pop_ctl,
	input  logic signed [VALUE_BITS-1:0] pop_value,
	input  logic signed [VALUE_BITS-1:0] pop_vec,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [ROW_IDX_W-1:0]         out_row_index,
	output logic [ACC_W-1:0]             out_dot_product
);

	logic                           adv;
	logic                           valid_s2;
	mvm_ctl_t                       ctl_s2;
	logic signed [2*VALUE_BITS-1:0] prod_s2;
	logic [ACC_W-1:0]               prod_ext, sum, acc_q;
	logic                           out_valid_q;
	logic [ROW_IDX_W-1:0]           out_row_q;
	logic [ACC_W-1:0]               out_dot_q;

	// Move the whole back end whenever the output register can take a beat
	assign adv = !out_valid_q || out_ready;
	assign pop = pop_valid && adv;

	assign prod_ext = ACC_W'(prod_s2);
	assign sum      = ctl_s2.first ? prod_ext : acc_q + prod_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s2    <= pop;
			out_valid_q <= valid_s2 && ctl_s2.last;
		end
	end

	// Multiply, then accumulate; a row's last element loads the result register
	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s2 <= (2*VALUE_BITS)'(pop_value) * (2*VALUE_BITS)'(pop_vec);
			ctl_s2  <= pop_ctl;
			if (valid_s2) begin
				acc_q <= sum;
				if (ctl_s2.last) begin
					out_row_q <= ctl_s2.row_index;
					out_dot_q <= sum;
				end
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign out_row_index   = out_row_q;
	assign out_dot_product = out_dot_q;

endmodule

// ===== rtl/core/matrix_vector_multiply_unit.sv =====
// Streaming matrix-vector multiply in fixed point.
// Slave channel: tuser is the item kind (0 loads the next vector element,
// 1 is the next matrix element, row-major); tdata holds the signed Q5.10
// value. Loads fill the vector store in order and wrap after num_cols
// elements; loading element 0 also restarts the row and column counts.
// Master channel: one beat per finished row, row index (first_row_index
// plus row count) and the exact dot product with 20 fraction bits.
// Configuration: write enable, register index and data; write only while idle.
// Throughput: one item per cycle while the receiver takes results, set by the single multiply-accumulate in
// the back end and the one-write, one-read port of the vector store.
// A row's result loads after its last element passes the front stage, the queue and the product register.
// A 4-entry queue between the front (counters, vector store) and the back
// (multiplier, accumulator, output register) decouples the two sides.
// Reset clears counters, registers to their defaults and empties the queue;
// the vector store is not cleared and must be loaded before use.
// When the receiver stalls, the result holds, the back end stops and the
// queue fills; s_tready drops once queued plus in-flight elements reach the queue depth.
module matrix_vector_multiply_unit import mvm_pkg::*; #(
	parameter int MAX_COLS   = DEF_MAX_COLS,
	parameter int VALUE_BITS = DEF_VALUE_BITS,
	localparam int IN_DATA_W = ((VALUE_BITS + 7) / 8) * 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // [VALUE_BITS-1:0] value
	input  logic                  s_tuser,   // [0] command
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata    // [16:0] row_index, [58:17] dot_product
);

	localparam int ENTRY_W = $bits(mvm_ctl_t) + 2 * VALUE_BITS;

	logic                         push, pop, nonempty;
	mvm_ctl_t                     push_ctl, pop_ctl;
	logic signed [VALUE_BITS-1:0] push_value, push_vec, pop_value, pop_vec;
	logic [ENTRY_W-1:0]           pop_data;
	logic [QCNT_W-1:0]            queue_count;
	logic [ROW_IDX_W-1:0]         row_index;
	logic [ACC_W-1:0]             dot_product;

	mvm_front #(
		.MAX_COLS   (MAX_COLS),
		.VALUE_BITS (VALUE_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_command  (s_tuser),
		.in_value    (s_tdata[VALUE_BITS-1:0]),
		.queue_count (queue_count),
		.push        (push),
		.push_ctl    (push_ctl),
		.push_value  (push_value),
		.push_vec    (push_vec)
	);

	mvm_queue #(
		.WIDTH (ENTRY_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_ctl, push_value, push_vec}),
		.pop       (pop),
		.pop_data  (pop_data),
		.nonempty  (nonempty),
		.count     (queue_count)
	);

	assign {pop_ctl, pop_value, pop_vec} = pop_data;

	mvm_back #(
		.VALUE_BITS (VALUE_BITS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.pop_valid       (nonempty),
		.pop             (pop),
		.pop_ctl         (pop_ctl),
		.pop_value       (pop_value),
		.pop_vec         (pop_vec),
		.out_valid       (m_tvalid),
		.out_ready       (m_tready),
		.out_row_index   (row_index),
		.out_dot_product (dot_product)
	);

	assign m_tdata = {{OUT_PAD_W{1'b0}}, dot_product, row_index};

endmodule

// ===== rtl/core/mvm_checker.sv =====
module mvm_checker import mvm_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata
);

	// A stalled result beat stays offered with the same contents
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// Bits above the dot product are padding
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[OUT_DATA_W-1:ROW_IDX_W+ACC_W] == '0)
		else $error("result padding not zero");

	// With no input and a ready receiver the queue drains and input reopens
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(!s_tvalid && m_tready) ##1 (!s_tvalid && m_tready) ##1
		(!s_tvalid && m_tready) ##1 (!s_tvalid && m_tready) ##1
		(!s_tvalid && m_tready) ##1 (!s_tvalid && m_tready) |-> s_tready)
		else $error("input not ready after back end drained");

endmodule

bind matrix_vector_multiply_unit mvm_checker u_checker (.*);

// ===== dv/matrix_vector_multiply_unit_tb.sv =====
module matrix_vector_multiply_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mvm_pkg::*;

	localparam int MAX_COLS      = DEF_MAX_COLS;
	localparam int VAL_W         = DEF_VALUE_BITS;
	localparam int SETTLE_CYCLES = 12;

	typedef struct packed {
		logic [ROW_IDX_W-1:0] row_index;
		logic [ACC_W-1:0]     dot_product;
	} row_result_t;

	// Track vector store, counters and accumulator; queue the rows due out
	class dot_product_tracker;
		logic [VAL_W-1:0]       vector_mem [MAX_COLS];
		bit                     loaded [MAX_COLS];
		logic [NUM_COLS_W-1:0]  num_cols;
		logic [NUM_ROWS_W-1:0]  num_rows;
		logic [FIRST_ROW_W-1:0] first_row;
		int unsigned            load_pos;
		int unsigned            col_pos;
		int unsigned            row_count;
		logic [ACC_W-1:0]       acc;
		row_result_t            expected_rows [$];
		int                     errors;

		function new();
			num_cols  = NUM_COLS_RESET;
			num_rows  = NUM_ROWS_RESET;
			first_row = FIRST_ROW_RESET;
			load_pos  = 0;
			col_pos   = 0;
			row_count = 0;
			acc       = '0;
			errors    = 0;
			foreach (loaded[i]) loaded[i] = 1'b0;
		endfunction

		// Zero columns act as one, anything past the store acts as the store size
		function int unsigned active_cols();
			if (num_cols == 0) return 1;
			if (num_cols > MAX_COLS) return MAX_COLS;
			return num_cols;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_NUM_COLS: num_cols = data[NUM_COLS_W-1:0];
				CFG_NUM_ROWS: num_rows = data[NUM_ROWS_W-1:0];
				CFG_FIRST_ROW: first_row = data[FIRST_ROW_W-1:0];
				default: ;
			endcase
		endfunction

		function void absorb_item(logic cmd, logic [VAL_W-1:0] raw);
			int unsigned cols;
			longint      product;
			row_result_t row;
			cols = active_cols();
			if (cmd == CMD_LOAD) begin
				// Element zero starts a new vector and restarts the row count
				if (load_pos == 0) begin
					col_pos   = 0;
					row_count = 0;
					acc       = '0;
				end
				vector_mem[load_pos] = raw;
				loaded[load_pos]     = 1'b1;
				load_pos = (load_pos + 1 >= cols) ? 0 : load_pos + 1;
			end else begin
				product = longint'($signed(raw)) * longint'($signed(vector_mem[col_pos]));
				acc = acc + product[ACC_W-1:0];
				// A position at or past the last column closes the row
				if (col_pos + 1 >= cols) begin
					row.row_index   = ROW_IDX_W'(first_row + row_count);
					row.dot_product = acc;
					expected_rows.push_back(row);
					acc       = '0;
					col_pos   = 0;
					row_count = (row_count + 1 >= num_rows) ? 0 : row_count + 1;
				end else begin
					col_pos++;
				end
			end
		endfunction

		function void match_row(logic [OUT_DATA_W-1:0] beat);
			row_result_t          want;
			logic [ROW_IDX_W-1:0] got_row;
			logic [ACC_W-1:0]     got_dot;
			got_row = beat[ROW_IDX_W-1:0];
			got_dot = beat[ROW_IDX_W +: ACC_W];
			if (expected_rows.size() == 0) begin
				errors++;
				$display("%0t: unexpected row beat: row_index %0d dot_product %0d",
					$time, got_row, $signed(got_dot));
				return;
			end
			want = expected_rows.pop_front();
			if (got_row !== want.row_index) begin
				errors++;
				$display("%0t: row_index mismatch: expected %0d, actual %0d",
					$time, want.row_index, got_row);
			end
			if (got_dot !== want.dot_product) begin
				errors++;
				$display("%0t: dot_product mismatch (row %0d): expected %0d, actual %0d",
					$time, want.row_index, $signed(want.dot_product), $signed(got_dot));
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [VAL_W-1:0]      s_tdata;
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;

	int send_idle_pct = 35;
	int recv_idle_pct = 54;

	dot_product_tracker tracker = new();

	matrix_vector_multiply_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Bail out if the block hangs
	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// Stall the result channel at random
	always @(negedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// Check every accepted result beat
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) tracker.match_row(m_tdata);
	end

	// Extremes four times in ten, otherwise any 16-bit pattern
	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return VAL_W'($urandom());
		endcase
	endfunction

	task automatic send_item(input logic cmd, input logic [VAL_W-1:0] raw);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= raw;
		do @(posedge clk); while (!s_tready);
		tracker.absorb_item(cmd, raw);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		tracker.set_register(idx, data);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Hold the input until every row is out, then let the pipeline settle
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (tracker.expected_rows.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Mostly complete vector loads and whole rows, with stray loads and pauses
	task automatic run_random_rows(input int count);
		logic cmd;
		repeat (count) begin
			if ($urandom_range(0, 149) == 0) drain();
			if (tracker.load_pos != 0)
				cmd = ($urandom_range(0, 9) == 0) ? CMD_MATRIX : CMD_LOAD;
			else
				cmd = ($urandom_range(0, 19) == 0) ? CMD_LOAD : CMD_MATRIX;
			// Never read a vector element that was not loaded yet
			if (cmd == CMD_MATRIX && !tracker.loaded[tracker.col_pos]) cmd = CMD_LOAD;
			send_item(cmd, pick_value());
		end
	endtask

	initial begin
		int                    random_sent;
		int                    len;
		int unsigned           cols;
		logic [CFG_DATA_W-1:0] word;
		logic [CFG_DATA_W-1:0] rows;
		logic [CFG_DATA_W-1:0] first;

		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = CFG_NUM_COLS;
		cfg_wdata = '0;
		s_tvalid  = 1'b0;
		s_tuser   = CMD_LOAD;
		s_tdata   = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Three columns, row count and offset left at reset values
		write_reg(CFG_NUM_COLS, 16'd3);
		send_item(CMD_LOAD, 16'h8000);
		send_item(CMD_LOAD, 16'h7FFF);
		send_item(CMD_LOAD, 16'hFFFF);
		repeat (3) send_item(CMD_MATRIX, 16'h8000);
		repeat (3) send_item(CMD_MATRIX, 16'h7FFF);
		// Reload element zero mid-row: drops the partial row, restarts counts
		send_item(CMD_MATRIX, 16'h0001);
		send_item(CMD_LOAD, 16'h0005);
		send_item(CMD_LOAD, 16'h0002);
		send_item(CMD_LOAD, 16'h8000);
		repeat (3) send_item(CMD_MATRIX, 16'hFFFF);
		drain();

		// Zero rows, top offset, column count with junk in the upper bits
		write_reg(CFG_NUM_ROWS, 16'd0);
		write_reg(CFG_FIRST_ROW, 16'hFFFF);
		write_reg(CFG_NUM_COLS, 16'hF804);
		send_item(CMD_LOAD, 16'h7FFF);
		send_item(CMD_LOAD, 16'h0000);
		send_item(CMD_LOAD, 16'h8000);
		send_item(CMD_LOAD, 16'h1234);
		send_item(CMD_MATRIX, 16'h8000);
		send_item(CMD_MATRIX, 16'h7FFF);
		send_item(CMD_MATRIX, 16'h0001);
		send_item(CMD_MATRIX, 16'hFFFF);
		repeat (3) send_item(CMD_MATRIX, 16'h8000);
		// Lower the column count under a partial row: next element closes it
		drain();
		write_reg(CFG_NUM_COLS, 16'd2);
		send_item(CMD_MATRIX, 16'h7FFF);

		// Random phases, each under a fresh setting
		random_sent = 0;
		while (random_sent < 880) begin
			if (random_sent >= 587) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end else if (random_sent >= 293) begin
				send_idle_pct = 54;
				recv_idle_pct = 35;
			end
			drain();
			case ($urandom_range(0, 19))
				0: cols = 0;
				1: cols = 1;
				2: cols = $urandom_range(16, 64);
				default: cols = $urandom_range(2, 8);
			endcase
			case ($urandom_range(0, 19))
				0: rows = 16'd0;
				1: rows = 16'hFFFF;
				2: rows = 16'd1;
				default: rows = CFG_DATA_W'($urandom_range(2, 6));
			endcase
			case ($urandom_range(0, 9))
				0: first = 16'd0;
				1: first = 16'hFFFF;
				default: first = CFG_DATA_W'($urandom());
			endcase
			word = CFG_DATA_W'($urandom());
			word[NUM_COLS_W-1:0] = cols[NUM_COLS_W-1:0];
			write_reg(CFG_NUM_COLS, word);
			write_reg(CFG_NUM_ROWS, rows);
			write_reg(CFG_FIRST_ROW, first);
			len = $urandom_range(20, 80);
			run_random_rows(len);
			random_sent += len;
		end

		// One column: two loads bring the load position back to element zero
		drain();
		write_reg(CFG_NUM_COLS, 16'd1);
		repeat (2) send_item(CMD_LOAD, pick_value());
		// Oversized column count: a partial row, then a lower count closes it
		drain();
		write_reg(CFG_NUM_COLS, 16'd2047);
		write_reg(CFG_NUM_ROWS, 16'hFFFF);
		write_reg(CFG_FIRST_ROW, CFG_DATA_W'($urandom()));
		repeat (9) send_item(CMD_LOAD, pick_value());
		repeat (8) send_item(CMD_MATRIX, pick_value());
		drain();
		write_reg(CFG_NUM_COLS, 16'd4);
		send_item(CMD_MATRIX, pick_value());

		drain();
		if (tracker.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
